// File: sv/batch_query_deframer_top_assert.svh
// assertion macros used by the checker of this block
`ifndef BATCH_QUERY_DEFRAMER_TOP_ASSERT_SVH
`define BATCH_QUERY_DEFRAMER_TOP_ASSERT_SVH

// checked only while reset is low
`define BQD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BQD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/bqd_pkg.sv
package bqd_pkg;

   localparam int LANES          = 16;
   localparam int LANE_W         = 32;
   localparam int SUB_W          = 64;
   localparam int WORD_W         = 512;
   localparam int LANE_IDX_W     = 4;
   localparam int LANE_CNT_W     = 5;
   localparam int CNT_W          = 31;
   localparam int CELL_WORD_W    = 27;
   localparam int QDEPTH         = 4;
   localparam int VECTOR_DIM_DEF = 128;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_CELL   = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_CENTER = 2'd3
   } kind_type;

   typedef struct packed {
      logic [63:0] in_word_7;
      logic [63:0] in_word_6;
      logic [63:0] in_word_5;
      logic [63:0] in_word_4;
      logic [63:0] in_word_3;
      logic [63:0] in_word_2;
      logic [63:0] in_word_1;
      logic [63:0] in_word_0;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] cell_id;
      logic [63:0]        out_word_0;
      logic [63:0]        out_word_1;
      logic [63:0]        out_word_2;
      logic [63:0]        out_word_3;
      logic [63:0]        out_word_4;
      logic [63:0]        out_word_5;
      logic [63:0]        out_word_6;
      logic [63:0]        out_word_7;
      logic               last_of_item;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      kind_type                kind;
      logic [LANE_CNT_W-1:0]   count;
      logic [WORD_W-1:0]       word;
   } entry_type;

endpackage

// File: sv/batch_query_deframer_top.sv
// channel   ports                            width
// req       req_push, req_full, req_data     512-bit stream word
// rsp       rsp_pop, rsp_empty, rsp_data     kind, cell id, 512-bit word, last
//
// header, query and center words: one word per cycle sustained unless rsp stalls
// cell-id words: 1 to 16 valid ids, the back end emits one id a cycle if not stalled
// a result reaches rsp once its word has passed through the queue
// and the output register; the front keeps taking words while the queue has room
// reset is synchronous; after a terminate header the block drops words until reset
module batch_query_deframer_top #(
   parameter int VECTOR_DIM = bqd_pkg::VECTOR_DIM_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bqd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bqd_pkg::rsp_type rsp_data
);

   logic               q_push, q_full, q_pop, q_empty;
   bqd_pkg::entry_type q_entry, q_head;

   assign req_full = q_full;

   bqd_front #(
      .VECTOR_DIM(VECTOR_DIM)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   bqd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   bqd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/bqd_front.sv
module bqd_front #(
   parameter int VECTOR_DIM = bqd_pkg::VECTOR_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  bqd_pkg::req_type   req_data,
   input  logic               q_full,
   output logic               q_push,
   output bqd_pkg::entry_type q_entry
);

   localparam int QWORDS = (VECTOR_DIM + bqd_pkg::LANES - 1) / bqd_pkg::LANES;
   localparam int VW_W   = $clog2(QWORDS + 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CELLS,
      PH_QUERY,
      PH_CENTER,
      PH_STOPPED
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [bqd_pkg::CNT_W-1:0]         qib_ff, qib_in;
   logic [bqd_pkg::CNT_W-1:0]         ppq_ff, ppq_in;
   logic [bqd_pkg::CNT_W-1:0]         qc_ff, qc_in;
   logic [bqd_pkg::CNT_W-1:0]         pc_ff, pc_in;
   logic [bqd_pkg::CELL_WORD_W-1:0]   cwc_ff, cwc_in;
   logic [VW_W-1:0]                   vwc_ff, vwc_in;

   logic                              accept;
   logic [bqd_pkg::WORD_W-1:0]        word;
   logic [31:0]                       hdr_b, hdr_p, hdr_t;
   logic [bqd_pkg::CNT_W-1:0]         b_pos, p_pos;
   logic [bqd_pkg::CNT_W-1:0]         remain, qc_inc, pc_inc;
   logic [VW_W-1:0]                   vwc_inc;

   assign accept = req_push && !q_full;
   assign word   = req_data;

   always_comb begin
      hdr_b   = word[31:0];
      hdr_p   = word[63:32];
      hdr_t   = word[95:64];
      b_pos   = hdr_b[31] ? '0 : hdr_b[bqd_pkg::CNT_W-1:0];
      p_pos   = hdr_p[31] ? '0 : hdr_p[bqd_pkg::CNT_W-1:0];
      remain  = ppq_ff - {cwc_ff, 4'b0000};
      qc_inc  = qc_ff + 1'b1;
      pc_inc  = pc_ff + 1'b1;
      vwc_inc = vwc_ff + 1'b1;

      phase_in = phase_ff;
      qib_in   = qib_ff;
      ppq_in   = ppq_ff;
      qc_in    = qc_ff;
      pc_in    = pc_ff;
      cwc_in   = cwc_ff;
      vwc_in   = vwc_ff;

      q_push        = accept && (phase_ff != PH_STOPPED);
      q_entry.word  = word;
      q_entry.count = bqd_pkg::LANE_CNT_W'(1);
      q_entry.kind  = bqd_pkg::KIND_HEADER;

      case (phase_ff)
         PH_HEADER: begin
            q_entry.kind = bqd_pkg::KIND_HEADER;
         end
         PH_CELLS: begin
            q_entry.kind  = bqd_pkg::KIND_CELL;
            q_entry.count = (remain > bqd_pkg::CNT_W'(bqd_pkg::LANES)) ?
                            bqd_pkg::LANE_CNT_W'(bqd_pkg::LANES) :
                            remain[bqd_pkg::LANE_CNT_W-1:0];
         end
         PH_QUERY: begin
            q_entry.kind = bqd_pkg::KIND_QUERY;
         end
         PH_CENTER: begin
            q_entry.kind = bqd_pkg::KIND_CENTER;
         end
         default: begin
            q_entry.kind = bqd_pkg::KIND_HEADER;
         end
      endcase

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_t != 32'd0) begin
                  phase_in = PH_STOPPED;
               end else begin
                  qib_in = b_pos;
                  ppq_in = p_pos;
                  qc_in  = '0;
                  if (b_pos == '0) begin
                     phase_in = PH_HEADER;
                  end else begin
                     cwc_in   = '0;
                     vwc_in   = '0;
                     pc_in    = '0;
                     phase_in = (p_pos != '0) ? PH_CELLS : PH_QUERY;
                  end
               end
            end
            PH_CELLS: begin
               cwc_in = cwc_ff + 1'b1;
               if (remain <= bqd_pkg::CNT_W'(bqd_pkg::LANES)) begin
                  vwc_in   = '0;
                  phase_in = PH_QUERY;
               end
            end
            PH_QUERY, PH_CENTER: begin
               vwc_in = vwc_inc;
               if (vwc_inc >= VW_W'(QWORDS)) begin
                  vwc_in = '0;
                  if (phase_ff == PH_QUERY && ppq_ff != '0) begin
                     pc_in    = '0;
                     phase_in = PH_CENTER;
                  end else if (phase_ff == PH_CENTER && pc_inc < ppq_ff) begin
                     pc_in = pc_inc;
                  end else begin
                     // query done
                     pc_in = pc_inc;
                     qc_in = qc_inc;
                     if (qc_inc >= qib_ff) begin
                        phase_in = PH_HEADER;
                     end else begin
                        cwc_in   = '0;
                        pc_in    = '0;
                        phase_in = (ppq_ff != '0) ? PH_CELLS : PH_QUERY;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         qib_ff   <= '0;
         ppq_ff   <= '0;
         qc_ff    <= '0;
         pc_ff    <= '0;
         cwc_ff   <= '0;
         vwc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         qib_ff   <= qib_in;
         ppq_ff   <= ppq_in;
         qc_ff    <= qc_in;
         pc_ff    <= pc_in;
         cwc_ff   <= cwc_in;
         vwc_ff   <= vwc_in;
      end
   end

endmodule

// File: sv/bqd_queue.sv
module bqd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bqd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output bqd_pkg::entry_type head
);

   localparam int PTR_W = $clog2(bqd_pkg::QDEPTH);
   localparam int CNT_W = $clog2(bqd_pkg::QDEPTH + 1);

   bqd_pkg::entry_type mem_ff [bqd_pkg::QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(bqd_pkg::QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: sv/bqd_back.sv
module bqd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  bqd_pkg::entry_type head,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output bqd_pkg::rsp_type   rsp_data
);

   logic                              out_valid_ff, out_valid_in;
   bqd_pkg::rsp_type                  out_data_ff, out_data_in;
   logic [bqd_pkg::LANE_IDX_W-1:0]    lane_ff, lane_in;
   logic                              fire, is_cell, last;
   logic [bqd_pkg::WORD_W-1:0]        fwd;

   assign fire    = !q_empty && (!out_valid_ff || rsp_pop);
   assign is_cell = (head.kind == bqd_pkg::KIND_CELL);
   assign last    = !is_cell ||
                    ({1'b0, lane_ff} + 1'b1 == head.count);
   assign q_pop   = fire && last;
   assign fwd     = is_cell ? '0 : head.word;

   always_comb begin
      out_data_in.kind         = head.kind;
      out_data_in.cell_id      = is_cell ?
                                 $signed(head.word[lane_ff*bqd_pkg::LANE_W +: bqd_pkg::LANE_W]) :
                                 32'sd0;
      out_data_in.out_word_0   = fwd[0*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_1   = fwd[1*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_2   = fwd[2*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_3   = fwd[3*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_4   = fwd[4*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_5   = fwd[5*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_6   = fwd[6*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.out_word_7   = fwd[7*bqd_pkg::SUB_W +: bqd_pkg::SUB_W];
      out_data_in.last_of_item = last;

      lane_in = lane_ff;
      if (fire) begin
         lane_in = last ? '0 : lane_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         lane_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         lane_ff      <= lane_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: sv/bqd_checker.sv
`include "batch_query_deframer_top_assert.svh"

module bqd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input bqd_pkg::rsp_type rsp_data
);

   // a waiting transaction holds until popped
   `BQD_ASSERT(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "rsp transaction changed while waiting")

   // cell ids carry no forwarded word
   `BQD_ASSERT(a_cell_no_word, (!rsp_empty && rsp_data.kind == bqd_pkg::KIND_CELL) |-> ((rsp_data.out_word_0 | rsp_data.out_word_1 | rsp_data.out_word_2 | rsp_data.out_word_3 | rsp_data.out_word_4 | rsp_data.out_word_5 | rsp_data.out_word_6 | rsp_data.out_word_7) == 64'd0), "cell id result carries word data")

   // forwarded words are single results with no cell id
   `BQD_ASSERT(a_word_single, (!rsp_empty && rsp_data.kind != bqd_pkg::KIND_CELL) |-> (rsp_data.last_of_item && rsp_data.cell_id == 32'sd0), "forwarded word not a single result")

   // after reset both sides are open and nothing waits
   `BQD_ASSERT_ALWAYS(a_reset_clear, $past(reset) |-> (rsp_empty && !req_full), "state not cleared by reset")

endmodule

bind batch_query_deframer_top bqd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// File: sim/testbench.sv
module testbench;

   localparam int VEC_WORDS = (bqd_pkg::VECTOR_DIM_DEF + bqd_pkg::LANES - 1) / bqd_pkg::LANES;
   localparam int RANDOM_WORDS = 400;

   typedef enum logic [2:0] {
      AWAIT_HEADER,
      AWAIT_CELLS,
      AWAIT_QUERY,
      AWAIT_CENTER,
      HALTED
   } stream_phase_type;

   class deframe_scoreboard;
      stream_phase_type  phase;
      int unsigned       query_total;
      int unsigned       probe_total;
      int unsigned       query_idx;
      int unsigned       cell_word_idx;
      int unsigned       probe_idx;
      int unsigned       vec_word_idx;
      bqd_pkg::rsp_type  expected_rsps[$];
      int unsigned       mismatches;
      int unsigned       dropped;
      int unsigned       kind_seen[4];

      function new();
         phase         = AWAIT_HEADER;
         query_total   = 0;
         probe_total   = 0;
         query_idx     = 0;
         cell_word_idx = 0;
         probe_idx     = 0;
         vec_word_idx  = 0;
         mismatches    = 0;
         dropped       = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function int unsigned pending();
         return expected_rsps.size();
      endfunction

      function void start_query();
         cell_word_idx = 0;
         vec_word_idx  = 0;
         probe_idx     = 0;
         phase         = (probe_total != 0) ? AWAIT_CELLS : AWAIT_QUERY;
      endfunction

      function void finish_query();
         query_idx++;
         if (query_idx >= query_total) begin
            phase = AWAIT_HEADER;
         end else begin
            start_query();
         end
      endfunction

      function void forward_word(bqd_pkg::kind_type k, bqd_pkg::req_type w);
         bqd_pkg::rsp_type r;
         r              = '0;
         r.kind         = k;
         r.out_word_0   = w.in_word_0;
         r.out_word_1   = w.in_word_1;
         r.out_word_2   = w.in_word_2;
         r.out_word_3   = w.in_word_3;
         r.out_word_4   = w.in_word_4;
         r.out_word_5   = w.in_word_5;
         r.out_word_6   = w.in_word_6;
         r.out_word_7   = w.in_word_7;
         r.last_of_item = 1'b1;
         expected_rsps.push_back(r);
      endfunction

      // predicts the results of one accepted stream word
      function void note_input(bqd_pkg::req_type w);
         logic [31:0]      b;
         logic [31:0]      p;
         logic [31:0]      t;
         logic [511:0]     flat;
         int unsigned      remain;
         int unsigned      n;
         bqd_pkg::rsp_type r;
         case (phase)
            AWAIT_HEADER: begin
               forward_word(bqd_pkg::KIND_HEADER, w);
               b = w.in_word_0[31:0];
               p = w.in_word_0[63:32];
               t = w.in_word_1[31:0];
               if (t != 0) begin
                  phase = HALTED;
               end else begin
                  // negative counts act as zero
                  query_total = b[31] ? 0 : b;
                  probe_total = p[31] ? 0 : p;
                  query_idx   = 0;
                  if (query_total == 0) begin
                     phase = AWAIT_HEADER;
                  end else begin
                     start_query();
                  end
               end
            end
            AWAIT_CELLS: begin
               flat   = w;
               remain = probe_total - cell_word_idx * bqd_pkg::LANES;
               n      = (remain > bqd_pkg::LANES) ? bqd_pkg::LANES : remain;
               for (int j = 0; j < n; j++) begin
                  r              = '0;
                  r.kind         = bqd_pkg::KIND_CELL;
                  r.cell_id      = flat[bqd_pkg::LANE_W*j +: bqd_pkg::LANE_W];
                  r.last_of_item = (j + 1 == n);
                  expected_rsps.push_back(r);
               end
               cell_word_idx++;
               if (cell_word_idx >= (probe_total + bqd_pkg::LANES - 1) / bqd_pkg::LANES) begin
                  vec_word_idx = 0;
                  phase        = AWAIT_QUERY;
               end
            end
            AWAIT_QUERY: begin
               forward_word(bqd_pkg::KIND_QUERY, w);
               vec_word_idx++;
               if (vec_word_idx >= VEC_WORDS) begin
                  vec_word_idx = 0;
                  if (probe_total != 0) begin
                     probe_idx = 0;
                     phase     = AWAIT_CENTER;
                  end else begin
                     finish_query();
                  end
               end
            end
            AWAIT_CENTER: begin
               forward_word(bqd_pkg::KIND_CENTER, w);
               vec_word_idx++;
               if (vec_word_idx >= VEC_WORDS) begin
                  vec_word_idx = 0;
                  probe_idx++;
                  if (probe_idx >= probe_total) finish_query();
               end
            end
            default: begin
               dropped++;
            end
         endcase
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(bqd_pkg::rsp_type got);
         bqd_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("result with no transaction waiting: kind %0d", got.kind);
            mismatches++;
            return;
         end
         want = expected_rsps.pop_front();
         kind_seen[want.kind]++;
         compare_field("kind", want.kind, got.kind);
         compare_field("cell_id", want.cell_id, got.cell_id);
         compare_field("out_word_0", want.out_word_0, got.out_word_0);
         compare_field("out_word_1", want.out_word_1, got.out_word_1);
         compare_field("out_word_2", want.out_word_2, got.out_word_2);
         compare_field("out_word_3", want.out_word_3, got.out_word_3);
         compare_field("out_word_4", want.out_word_4, got.out_word_4);
         compare_field("out_word_5", want.out_word_5, got.out_word_5);
         compare_field("out_word_6", want.out_word_6, got.out_word_6);
         compare_field("out_word_7", want.out_word_7, got.out_word_7);
         compare_field("last_of_item", want.last_of_item, got.last_of_item);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_push;
   logic             req_full;
   bqd_pkg::req_type req_data;
   logic             rsp_empty;
   logic             rsp_pop;
   bqd_pkg::rsp_type rsp_data;

   deframe_scoreboard sb = new();
   bit          steady = 1'b0;
   int unsigned words_sent = 0;

   batch_query_deframer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("** batch_query_deframer_top: FAILED **");
      $finish;
   end

   function automatic bqd_pkg::req_type random_word();
      logic [511:0] flat;
      for (int i = 0; i < 16; i++) flat[32*i +: 32] = $urandom;
      return bqd_pkg::req_type'(flat);
   endfunction

   function automatic bqd_pkg::req_type header_word(logic [31:0] batch, logic [31:0] probes,
                                                    logic [31:0] stop);
      bqd_pkg::req_type w;
      w                 = random_word();
      w.in_word_0       = {probes, batch};
      w.in_word_1[31:0] = stop;
      return w;
   endfunction

   // one transaction on the stream side, returns at a falling edge
   task automatic send_word(input bqd_pkg::req_type w);
      bit taken;
      while (!steady && $urandom_range(99) < 7) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      do begin
         @(posedge clock);
         taken = (req_full === 1'b0);
         if (taken) sb.note_input(w);
         @(negedge clock);
      end while (!taken);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic send_random_header(input bit big);
      int unsigned pct;
      logic [31:0] batch;
      logic [31:0] probes;
      pct = $urandom_range(99);
      if (pct < 10) batch = 0;
      else if (pct < 18) batch = {1'b1, 31'($urandom)};
      else batch = $urandom_range(3, 1);
      pct = $urandom_range(99);
      if (pct < 20) probes = 0;
      else if (pct < 75) probes = $urandom_range(3, 1);
      else if (pct < 87) probes = $urandom_range(15, 4);
      else if (pct < 92) probes = bqd_pkg::LANES;
      else probes = {1'b1, 31'($urandom)};
      if (big) begin
         batch  = 1;
         probes = bqd_pkg::LANES + 1;
      end
      if (!probes[31] && probes > 3 && !batch[31] && batch > 1) batch = 1;
      send_word(header_word(batch, probes, 32'd0));
   endtask

   task automatic send_random_body();
      bqd_pkg::req_type w;
      logic [511:0]     flat;
      logic [31:0]      extremes[4];
      extremes = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      w = random_word();
      if (sb.phase == AWAIT_CELLS && $urandom_range(99) < 10) begin
         for (int i = 0; i < bqd_pkg::LANES; i++) begin
            flat[bqd_pkg::LANE_W*i +: bqd_pkg::LANE_W] = extremes[$urandom_range(3)];
         end
         w = bqd_pkg::req_type'(flat);
      end else if ($urandom_range(99) < 5) begin
         // header-shaped word in the middle of a batch is just data
         w = header_word($urandom_range(3), $urandom_range(3), $urandom_range(1));
      end
      send_word(w);
   endtask

   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && rsp_empty === 1'b0) sb.check_result(rsp_data);
         @(negedge clock);
         rsp_pop <= steady || ($urandom_range(99) >= 7);
      end
   end

   initial begin
      logic [511:0] flat;
      int unsigned  guard;
      bit           big_done;
      logic [31:0]  stop;

      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      big_done = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty batch, negative batch size, negative probe count
      send_word(header_word(32'd0, 32'd7, 32'd0));
      send_word(header_word(32'h8000_0000 | $urandom, 32'd2, 32'd0));
      send_word(header_word(32'd1, 32'hffff_ffff, 32'd0));
      send_word(bqd_pkg::req_type'({512{1'b1}}));
      send_word(bqd_pkg::req_type'(512'd0));
      for (int i = 2; i < VEC_WORDS; i++) send_word(random_word());

      // one probe: only lane 0 of the cell word is valid
      send_word(header_word(32'd1, 32'd1, 32'd0));
      flat = {bqd_pkg::LANES{32'hffff_ffff}};
      flat[bqd_pkg::LANE_W-1:0] = 32'h8000_0000;
      send_word(bqd_pkg::req_type'(flat));
      for (int i = 0; i < 2 * VEC_WORDS; i++) send_word(random_word());

      wait_drained();

      words_sent = 0;
      while (words_sent < RANDOM_WORDS || sb.phase != AWAIT_HEADER) begin
         steady = (words_sent >= 150 && words_sent < 270);
         if (words_sent == 330) wait_drained();
         if (sb.phase == AWAIT_HEADER) begin
            send_random_header(!big_done && words_sent >= 200);
            if (words_sent >= 200) big_done = 1'b1;
         end else begin
            send_random_body();
         end
      end
      steady = 1'b0;

      // terminate, then words that must be dropped
      stop = $urandom;
      if (stop == 0) stop = 32'd1;
      send_word(header_word($urandom_range(3, 1), $urandom_range(3, 1), stop));
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 0) send_word(header_word(32'd1, 32'd1, 32'd0));
         else send_word(random_word());
      end
      req_push <= 1'b0;

      guard = 0;
      while (sb.pending() != 0 && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("stream covered %0d headers, %0d cell ids, %0d query words, %0d center words",
               sb.kind_seen[bqd_pkg::KIND_HEADER], sb.kind_seen[bqd_pkg::KIND_CELL],
               sb.kind_seen[bqd_pkg::KIND_QUERY], sb.kind_seen[bqd_pkg::KIND_CENTER]);
      $display("after the terminate header %0d words were dropped; %0d mismatches",
               sb.dropped, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("** batch_query_deframer_top: PASSED **");
      end else begin
         $display("** batch_query_deframer_top: FAILED **");
      end
      $finish;
   end

endmodule
